// ----- design/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

    // screen geometry defaults
    localparam int unsigned TCC_COLUMNS   = 80;
    localparam int unsigned TCC_ROWS      = 25;
    localparam int unsigned TCC_TAB_WIDTH = 8;

    localparam int unsigned MODE_W     = 3;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned ATTR_W     = 8;
    localparam int unsigned COL_W      = 7;
    localparam int unsigned ROW_W      = 5;
    localparam int unsigned IDX_W      = 11;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 3'd0,
        MODE_CLEAR = 3'd1,
        MODE_HOME  = 3'd2,
        MODE_LEFT  = 3'd3,
        MODE_RIGHT = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_ATTR = 1'b0,
        REG_BS_FLOOR  = 1'b1
    } cfg_reg_t;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
    localparam logic [COL_W-1:0]  FLOOR_RESET = 7'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] char_code;
    } cmd_t;

    typedef struct packed {
        logic              write_valid;
        logic [IDX_W-1:0]  cell_index;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attribute;
        logic              scroll_up;
        logic              clear_screen;
        logic [IDX_W-1:0]  cursor_index;
    } res_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cursor_t;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [COL_W-1:0]  floor;
    } cfg_t;

endpackage

`default_nettype wire

// ----- design/tcc_stream_if.sv -----
`default_nettype none

interface tcc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/text_console_cursor_engine.sv -----
// The result of an accepted command is registered and appears in the cycle after it is taken.
// Throughput: one command per cycle; the cursor update is a single pass of logic
// on the column and row registers. A command is taken when the result register
// is empty or its beat is taken in the same cycle, so a result that is held off
// also holds off the input.
// Reset: cursor to column 0 row 0, attribute 0x0F, backspace floor 5, output empty.
`default_nettype none

module text_console_cursor_engine #(
    parameter int unsigned COLUMNS   = tcc_pkg::TCC_COLUMNS,
    parameter int unsigned ROWS      = tcc_pkg::TCC_ROWS,
    parameter int unsigned TAB_WIDTH = tcc_pkg::TCC_TAB_WIDTH
) (
    input  wire                               clk,
    input  wire                               rst_n,
    tcc_stream_if.sink                        cmd,
    tcc_stream_if.source                      res,
    input  wire                               cfg_we,
    input  wire [tcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [tcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tcc_pkg::cursor_t cursor_reg;
    tcc_pkg::cursor_t cursor_next;
    tcc_pkg::cfg_t    cfg_reg;
    tcc_pkg::res_t    res_reg;
    tcc_pkg::res_t    res_next;
    logic             res_valid_reg;
    logic             accept;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    tcc_step #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_step (
        .cmd (cmd.data),
        .cur (cursor_reg),
        .cfg (cfg_reg),
        .nxt (cursor_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cursor_reg <= cursor_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attr  <= tcc_pkg::ATTR_RESET;
            cfg_reg.floor <= tcc_pkg::FLOOR_RESET;
        end
        else if (cfg_we)
        begin
            case (tcc_pkg::cfg_reg_t'(cfg_index))
                tcc_pkg::REG_TEXT_ATTR: cfg_reg.attr  <= cfg_data[tcc_pkg::ATTR_W-1:0];
                tcc_pkg::REG_BS_FLOOR:  cfg_reg.floor <= cfg_data[tcc_pkg::COL_W-1:0];
                default:                cfg_reg       <= cfg_reg;
            endcase
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

endmodule

`default_nettype wire

// ----- design/tcc_step.sv -----
`default_nettype none

module tcc_step #(
    parameter int unsigned COLUMNS   = tcc_pkg::TCC_COLUMNS,
    parameter int unsigned ROWS      = tcc_pkg::TCC_ROWS,
    parameter int unsigned TAB_WIDTH = tcc_pkg::TCC_TAB_WIDTH
) (
    input  var tcc_pkg::cmd_t    cmd,
    input  var tcc_pkg::cursor_t cur,
    input  var tcc_pkg::cfg_t    cfg,
    output tcc_pkg::cursor_t     nxt,
    output tcc_pkg::res_t        res
);

    localparam int unsigned CW = tcc_pkg::COL_W;
    localparam int unsigned RW = tcc_pkg::ROW_W;
    localparam int unsigned IW = tcc_pkg::IDX_W;
    localparam int unsigned TAB_DEPTH = 1 << CW;

    localparam logic [CW:0] COL_LAST = (CW+1)'(COLUMNS - 1);
    localparam logic [RW:0] ROW_LAST = (RW+1)'(ROWS - 1);

    typedef logic [CW:0] tab_tbl_t [TAB_DEPTH];

    // next tab stop for every column, built without division
    function automatic tab_tbl_t build_tab();
        tab_tbl_t    t;
        int unsigned stop;
        stop = TAB_WIDTH;
        for (int unsigned i = 0; i < TAB_DEPTH; i++)
        begin
            if (i == stop)
            begin
                stop = stop + TAB_WIDTH;
            end
            t[i] = (CW+1)'(stop);
        end
        return t;
    endfunction

    localparam tab_tbl_t TAB_NEXT = build_tab();

    function automatic logic [IW-1:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
        logic [IW:0] p;
        p = (IW+1)'(r) * (IW+1)'(COLUMNS) + (IW+1)'(c);
        return p[IW-1:0];
    endfunction

    logic [CW:0]                 c;
    logic [RW:0]                 r;
    logic                        wr;
    logic                        scroll;
    logic                        clr;
    logic [tcc_pkg::CHAR_W-1:0]  wch;
    logic [CW-1:0]               wcol;
    logic                        above_floor;

    assign above_floor = cur.col > cfg.floor;

    always_comb
    begin
        c      = {1'b0, cur.col};
        r      = {1'b0, cur.row};
        wr     = 1'b0;
        scroll = 1'b0;
        clr    = 1'b0;
        wch    = '0;
        wcol   = cur.col;
        case (tcc_pkg::mode_t'(cmd.mode))
            tcc_pkg::MODE_PUT:
            begin
                case (cmd.char_code)
                    tcc_pkg::CH_LF:
                    begin
                        c = '0;
                        r = r + 1'b1;
                    end
                    tcc_pkg::CH_CR:
                    begin
                        c = '0;
                    end
                    tcc_pkg::CH_BS:
                    begin
                        if (above_floor)
                        begin
                            c    = c - 1'b1;
                            wr   = 1'b1;
                            wch  = tcc_pkg::CH_SPACE;
                            wcol = cur.col - 1'b1;
                        end
                    end
                    tcc_pkg::CH_TAB:
                    begin
                        c = TAB_NEXT[cur.col];
                    end
                    default:
                    begin
                        if (cmd.char_code >= tcc_pkg::CH_SPACE)
                        begin
                            wr  = 1'b1;
                            wch = cmd.char_code;
                            c   = c + 1'b1;
                        end
                    end
                endcase
                // wrap past the last column, then scroll past the last row
                if (c > COL_LAST)
                begin
                    c = '0;
                    r = r + 1'b1;
                end
                if (r > ROW_LAST)
                begin
                    scroll = 1'b1;
                    r      = ROW_LAST;
                end
            end
            tcc_pkg::MODE_CLEAR:
            begin
                clr = 1'b1;
                c   = '0;
                r   = '0;
            end
            tcc_pkg::MODE_HOME:
            begin
                c = '0;
                r = '0;
            end
            tcc_pkg::MODE_LEFT:
            begin
                if (above_floor)
                begin
                    c = c - 1'b1;
                end
            end
            tcc_pkg::MODE_RIGHT:
            begin
                if (c < COL_LAST)
                begin
                    c = c + 1'b1;
                end
            end
            default:
            begin
                c = {1'b0, cur.col};
            end
        endcase
    end

    assign nxt.col = c[CW-1:0];
    assign nxt.row = r[RW-1:0];

    assign res.write_valid    = wr;
    assign res.cell_index     = wr ? lin(cur.row, wcol) : '0;
    assign res.cell_char      = wr ? wch : '0;
    assign res.cell_attribute = wr ? cfg.attr : '0;
    assign res.scroll_up      = scroll;
    assign res.clear_screen   = clr;
    assign res.cursor_index   = lin(r[RW-1:0], c[CW-1:0]);

endmodule

`default_nettype wire

// ----- design/tcc_checker.sv -----
`default_nettype none

module tcc_checker #(
    parameter int unsigned COLUMNS = tcc_pkg::TCC_COLUMNS,
    parameter int unsigned ROWS    = tcc_pkg::TCC_ROWS
) (
    input wire                clk,
    input wire                rst_n,
    input wire                cmd_ready,
    input wire                res_valid,
    input wire                res_ready,
    input wire tcc_pkg::res_t res_data
);

    localparam logic [tcc_pkg::IDX_W-1:0] LAST_ROW_START =
        tcc_pkg::IDX_W'((ROWS - 1) * COLUMNS);

    // a held result must not change under back-pressure
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // an empty output stage always takes a command
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("command refused with output stage empty");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.write_valid |->
            res_data.cell_index == '0 && res_data.cell_char == '0 &&
            res_data.cell_attribute == '0)
        else $error("cell fields set without a write");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.clear_screen |->
            res_data.cursor_index == '0 && !res_data.write_valid && !res_data.scroll_up)
        else $error("clear did not home the cursor");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.scroll_up |-> res_data.cursor_index >= LAST_ROW_START)
        else $error("scroll with cursor off the last row");

endmodule

bind text_console_cursor_engine tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);

`default_nettype wire
